// ===== rtl/softened_gravity_accumulator_defines.svh =====
// assertion macros shared by sga_queue, sga_div and sga_back
// each macro expects signals named clk and rst in the calling scope
`ifndef SOFTENED_GRAVITY_ACCUMULATOR_DEFINES_SVH
`define SOFTENED_GRAVITY_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define SGA_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sga check failed");

// next-cycle implication
`define SGA_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sga check failed");

`endif

// ===== rtl/sga_pkg.sv =====
// ----------------------------------------------------------------------------
// sga_pkg
// Types and fixed-point constants of the softened gravity accumulator.
// ----------------------------------------------------------------------------
package sga_pkg;

  localparam int COORD_W         = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int ACC_FRAC_BITS   = 24;
  localparam int SQRT_EXTRA_BITS = 16;
  localparam int ACC_WIDTH       = 48;
  localparam int MAG_W           = ACC_WIDTH - 1;
  localparam int PROD_W          = 2 * COORD_W;
  localparam int D2_W            = 64;
  localparam int ROOT_W          = 48;
  localparam int RAD_W           = 2 * ROOT_W;
  localparam int DEN_W           = D2_W + ROOT_W;
  localparam int NUM_SHIFT       = COORD_FRAC_BITS + ACC_FRAC_BITS + SQRT_EXTRA_BITS;
  localparam int NUM_W           = PROD_W + NUM_SHIFT;
  localparam int QUEUE_DEPTH     = 2;
  localparam int NUM_AXES        = 3;

  localparam logic [COORD_W-1:0] SOFTENING_RESET = 32'd43;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] source_x;
    logic signed [COORD_W-1:0] source_y;
    logic signed [COORD_W-1:0] source_z;
    logic        [COORD_W-1:0] source_mass;
    logic                      first_item;
    logic                      last_item;
  } in_word_t;

  typedef struct packed {
    logic signed [ACC_WIDTH-1:0] accel_x;
    logic signed [ACC_WIDTH-1:0] accel_y;
    logic signed [ACC_WIDTH-1:0] accel_z;
  } out_word_t;

  // one queued interaction: per-axis sign and magnitude of source - target
  typedef struct packed {
    logic [NUM_AXES-1:0]              neg;
    logic [NUM_AXES-1:0][COORD_W-1:0] mag;
    logic [COORD_W-1:0]               mass;
    logic                             first;
    logic                             last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

endpackage

// ===== rtl/softened_gravity_accumulator.sv =====
// ----------------------------------------------------------------------------
// softened_gravity_accumulator
// Plummer-softened point-mass acceleration, summed over a run of interactions.
// ----------------------------------------------------------------------------
// One interaction is accepted into a two-word queue whenever the queue has room
// and is then worked through one at a time: a 48-step bit-serial square root
// and three divisions of up to 47 steps on one shared divider dominate the work,
// alongside the shared 32x32 multiplier.
// A word with last_item set produces one result word after its own interaction
// is added; that result waits in an output register while the next interaction
// is already being processed. softening_sq may be written at any time the block
// is idle and takes effect on the next interaction.
module softened_gravity_accumulator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  sga_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sga_pkg::out_word_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sga_pkg::COORD_W-1:0]  cfg_data
);

  logic [sga_pkg::COORD_W-1:0] softening_sq;
  sga_pkg::entry_t             push_entry;
  sga_pkg::entry_t             head;
  sga_pkg::queue_status_t      qstat;
  logic                        push;
  logic                        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      softening_sq <= sga_pkg::SOFTENING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      softening_sq <= cfg_data;
    end
  end

  sga_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .qstat    (qstat),
    .push     (push),
    .entry    (push_entry)
  );

  sga_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  sga_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .softening_sq (softening_sq),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ===== rtl/sga_front.sv =====
// ----------------------------------------------------------------------------
// sga_front
// Accepts interaction words and reduces them to per-axis sign and magnitude.
// ----------------------------------------------------------------------------
module sga_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  sga_pkg::in_word_t        in_data,
  input  sga_pkg::queue_status_t   qstat,
  output logic                     push,
  output sga_pkg::entry_t          entry
);

  logic [sga_pkg::NUM_AXES-1:0][sga_pkg::COORD_W-1:0] src;
  logic [sga_pkg::NUM_AXES-1:0][sga_pkg::COORD_W-1:0] tgt;
  logic [sga_pkg::COORD_W:0] diff [sga_pkg::NUM_AXES];
  logic [sga_pkg::COORD_W:0] negd [sga_pkg::NUM_AXES];

  assign src = {in_data.source_z, in_data.source_y, in_data.source_x};
  assign tgt = {in_data.target_z, in_data.target_y, in_data.target_x};

  always_comb begin
    for (int i = 0; i < sga_pkg::NUM_AXES; i++) begin
      diff[i] = {src[i][sga_pkg::COORD_W-1], src[i]} - {tgt[i][sga_pkg::COORD_W-1], tgt[i]};
      negd[i] = '0 - diff[i];
      entry.neg[i] = diff[i][sga_pkg::COORD_W];
      // magnitude stays below 2^32
      entry.mag[i] = diff[i][sga_pkg::COORD_W] ? negd[i][sga_pkg::COORD_W-1:0]
                                               : diff[i][sga_pkg::COORD_W-1:0];
    end
    entry.mass  = in_data.source_mass;
    entry.first = in_data.first_item;
    entry.last  = in_data.last_item;
  end

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

endmodule

// ===== rtl/sga_queue.sv =====
// ----------------------------------------------------------------------------
// sga_queue
// Short fifo of classified interactions between front and back.
// ----------------------------------------------------------------------------
`include "softened_gravity_accumulator_defines.svh"

module sga_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sga_pkg::entry_t        push_entry,
  input  logic                   pop,
  output sga_pkg::entry_t        head,
  output sga_pkg::queue_status_t qstat
);

  localparam int PW = (sga_pkg::QUEUE_DEPTH > 1) ? $clog2(sga_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(sga_pkg::QUEUE_DEPTH + 1);

  sga_pkg::entry_t slots [sga_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(sga_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(sga_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head            = slots[rd_ptr];
  assign qstat.full      = (count == CW'(sga_pkg::QUEUE_DEPTH));
  assign qstat.not_empty = (count != '0);

  `SGA_ASSERT_IMP(a_no_pop_empty, pop, count != '0)
  `SGA_ASSERT_NXT(a_push_fills, push && !pop, count != '0)

endmodule

// ===== rtl/sga_sqrt.sv =====
// ----------------------------------------------------------------------------
// sga_sqrt
// Bit-serial integer square root of d2 * 2^32, one root bit per cycle.
// ----------------------------------------------------------------------------
module sga_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sga_pkg::D2_W-1:0]    d2,
  output logic                        done,
  output logic [sga_pkg::ROOT_W-1:0]  root
);

  localparam int REM_W = sga_pkg::ROOT_W + 3;
  localparam int CNT_W = $clog2(sga_pkg::ROOT_W);

  logic [sga_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]          rem;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          trial;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      ge;

  assign rem_sh = {rem[REM_W-3:0], rad[sga_pkg::RAD_W-1 -: 2]};
  assign trial  = REM_W'({root, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {d2, {(sga_pkg::RAD_W - sga_pkg::D2_W){1'b0}}};
      rem  <= '0;
      root <= '0;
      cnt  <= CNT_W'(sga_pkg::ROOT_W - 1);
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[sga_pkg::ROOT_W-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end

endmodule

// ===== rtl/sga_div.sv =====
// ----------------------------------------------------------------------------
// sga_div
// Restoring divider, one quotient bit per cycle, clamped to the sum limit.
// ----------------------------------------------------------------------------
`include "softened_gravity_accumulator_defines.svh"

module sga_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sga_pkg::NUM_W-1:0]   num,
  input  logic [sga_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [sga_pkg::MAG_W-1:0]   q
);

  localparam int HI_W  = sga_pkg::NUM_W - sga_pkg::MAG_W;
  localparam int CNT_W = $clog2(sga_pkg::MAG_W);

  logic [HI_W-1:0]              hi;
  logic [sga_pkg::DEN_W-1:0]    hi_ext;
  logic [sga_pkg::DEN_W-1:0]    rem;
  logic [sga_pkg::MAG_W-1:0]    sh;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic                         clamp;
  logic [sga_pkg::DEN_W:0]      trial;
  logic [sga_pkg::DEN_W:0]      diff;
  logic                         ge;

  assign hi     = num[sga_pkg::NUM_W-1:sga_pkg::MAG_W];
  assign hi_ext = sga_pkg::DEN_W'(hi);
  // quotient exceeds the limit exactly when the upper numerator part is not below den
  assign clamp  = (hi_ext >= den);
  assign trial  = {rem, sh[sga_pkg::MAG_W-1]};
  assign diff   = trial - {1'b0, den};
  assign ge     = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !clamp;
        done <= clamp;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= clamp ? '1 : '0;
      rem <= hi_ext;
      sh  <= num[sga_pkg::MAG_W-1:0];
      cnt <= CNT_W'(sga_pkg::MAG_W - 1);
    end else if (busy) begin
      rem <= ge ? diff[sga_pkg::DEN_W-1:0] : trial[sga_pkg::DEN_W-1:0];
      q   <= {q[sga_pkg::MAG_W-2:0], ge};
      sh  <= sh << 1;
      cnt <= cnt - 1'b1;
    end
  end

  `SGA_ASSERT_IMP(a_rem_below_den, busy, rem < den)

endmodule

// ===== rtl/sga_back.sv =====
// ----------------------------------------------------------------------------
// sga_back
// Sequencer: distance, root, denominator, three divisions, accumulation and output.
// ----------------------------------------------------------------------------
`include "softened_gravity_accumulator_defines.svh"

module sga_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sga_pkg::entry_t               head,
  input  sga_pkg::queue_status_t        qstat,
  output logic                          pop,
  input  logic [sga_pkg::COORD_W-1:0]   softening_sq,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sga_pkg::out_word_t            out_data
);

  localparam int W = sga_pkg::ACC_WIDTH;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SQ    = 8'b0000_0010,
    S_ROOT  = 8'b0000_0100,
    S_DEN   = 8'b0000_1000,
    S_MAG   = 8'b0001_0000,
    S_START = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t                          state;
  sga_pkg::entry_t                 cur;
  logic [2:0]                      cnt;
  logic [1:0]                      comp;
  logic [sga_pkg::D2_W-1:0]        d2;
  logic [sga_pkg::D2_W-1:0]        d2_add;
  logic [sga_pkg::D2_W:0]          d2_raw;
  logic [sga_pkg::D2_W-1:0]        d2_sum;
  logic [sga_pkg::DEN_W-1:0]       den;
  logic [sga_pkg::DEN_W-1:0]       den_add;
  logic [sga_pkg::COORD_W-1:0]     mul_a;
  logic [sga_pkg::COORD_W-1:0]     mul_b;
  logic [sga_pkg::PROD_W-1:0]      prod;
  logic signed [W-1:0]             sums [sga_pkg::NUM_AXES];
  logic [W:0]                      acc_ext;
  logic [W:0]                      acc_mag;
  logic [W:0]                      acc_raw;
  logic [W-1:0]                    acc_res;
  logic                            sqrt_start;
  logic                            sqrt_done;
  logic [sga_pkg::ROOT_W-1:0]      root;
  logic                            div_start;
  logic                            div_done;
  logic [sga_pkg::MAG_W-1:0]       q;
  logic                            emit_go;

  sga_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .d2    (d2_sum),
    .done  (sqrt_done),
    .root  (root)
  );

  sga_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({prod, {sga_pkg::NUM_SHIFT{1'b0}}}),
    .den   (den),
    .done  (div_done),
    .q     (q)
  );

  // shared 32x32 multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        case (cnt)
          3'd0: begin
            mul_a = cur.mag[0];
            mul_b = cur.mag[0];
          end
          3'd1: begin
            mul_a = cur.mag[1];
            mul_b = cur.mag[1];
          end
          3'd2: begin
            mul_a = cur.mag[2];
            mul_b = cur.mag[2];
          end
          default: ;
        endcase
      end
      S_DEN: begin
        mul_a = cnt[0] ? d2[63:32] : d2[31:0];
        mul_b = cnt[1] ? sga_pkg::COORD_W'(root[47:32]) : root[31:0];
      end
      S_MAG: begin
        mul_a = cur.mass;
        mul_b = cur.mag[comp];
      end
      default: ;
    endcase
  end

  // saturating squared-distance sum
  always_comb begin
    case (cnt)
      3'd2, 3'd3: d2_add = prod;
      3'd4:       d2_add = sga_pkg::D2_W'(softening_sq);
      default:    d2_add = '0;
    endcase
    d2_raw = {1'b0, d2} + {1'b0, d2_add};
    d2_sum = d2_raw[sga_pkg::D2_W] ? '1 : d2_raw[sga_pkg::D2_W-1:0];
  end

  // partial products of d2 * root
  always_comb begin
    case (cnt)
      3'd1:       den_add = sga_pkg::DEN_W'(prod);
      3'd2, 3'd3: den_add = sga_pkg::DEN_W'(prod) << 32;
      3'd4:       den_add = sga_pkg::DEN_W'(prod) << 64;
      default:    den_add = '0;
    endcase
  end

  // saturating signed add of the clamped magnitude
  always_comb begin
    acc_ext = {sums[comp][W-1], sums[comp]};
    acc_mag = {2'b00, q};
    acc_raw = cur.neg[comp] ? acc_ext - acc_mag : acc_ext + acc_mag;
    if (acc_raw[W] != acc_raw[W-1]) begin
      acc_res = acc_raw[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      acc_res = acc_raw[W-1:0];
    end
  end

  assign pop        = (state == S_IDLE) && qstat.not_empty;
  assign sqrt_start = (state == S_SQ) && (cnt == 3'd4);
  assign div_start  = (state == S_START);
  assign emit_go    = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      comp      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < sga_pkg::NUM_AXES; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (qstat.not_empty) begin
            if (head.first) begin
              for (int i = 0; i < sga_pkg::NUM_AXES; i++) begin
                sums[i] <= '0;
              end
            end
            cnt   <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd4) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_done) begin
            cnt   <= '0;
            state <= S_DEN;
          end
        end
        S_DEN: begin
          cnt <= cnt + 1'b1;
          if (cnt == 3'd4) begin
            comp  <= '0;
            state <= S_MAG;
          end
        end
        S_MAG: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            // zero denominator: coincident points with no softening add nothing
            if (den != '0) begin
              sums[comp] <= acc_res;
            end
            if (comp == 2'd2) begin
              state <= cur.last ? S_EMIT : S_IDLE;
            end else begin
              comp  <= comp + 1'b1;
              state <= S_MAG;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == S_SQ) begin
      if (cnt == 3'd1) begin
        d2 <= prod;
      end else if (cnt != 3'd0) begin
        d2 <= d2_sum;
      end
    end
    if (state == S_ROOT) begin
      den <= '0;
    end else if (state == S_DEN && cnt != 3'd0) begin
      den <= den + den_add;
    end
    if (emit_go) begin
      out_data.accel_x <= sums[0];
      out_data.accel_y <= sums[1];
      out_data.accel_z <= sums[2];
    end
  end

  `SGA_ASSERT_IMP(a_emit_only_last, state == S_EMIT, cur.last)
  `SGA_ASSERT_IMP(a_pop_only_idle, pop, state == S_IDLE)

endmodule
